// ===== hw/rtl/ride_motion_impact_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ride motion impact classifier
// Concurrent assertion helpers clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RIDE_MOTION_IMPACT_CLASSIFIER_ASSERT_SVH
`define RIDE_MOTION_IMPACT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define RMIC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define RMIC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rmic_pkg.sv =====
// ----------------------------------------------------------------------------
// rmic_pkg
// Codes, widths and register reset values of the ride motion impact classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmic_pkg;

  localparam int AddrW = 5;

  // Command opcodes.
  localparam logic [2:0] OP_SAMPLE = 3'd0;
  localparam logic [2:0] OP_SECOND = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;
  localparam logic [2:0] OP_ACK    = 3'd5;
  localparam logic [2:0] OP_FINISH = 3'd6;

  // Motion and alert codes.
  localparam logic [1:0] MOTION_UNKNOWN = 2'd0;
  localparam logic [1:0] MOTION_STILL   = 2'd1;
  localparam logic [1:0] MOTION_MOVING  = 2'd2;
  localparam logic [1:0] ALERT_NONE     = 2'd0;
  localparam logic [1:0] ALERT_IMPACT   = 2'd1;
  localparam logic [1:0] ALERT_STILL    = 2'd2;
  localparam logic [1:0] ALERT_REST     = 2'd3;

  // Register indexes (byte address bits [4:2]).
  localparam logic [2:0] REG_MOVE_ACCEL   = 3'd0;
  localparam logic [2:0] REG_MOVE_GYRO    = 3'd1;
  localparam logic [2:0] REG_IMPACT_ACCEL = 3'd2;
  localparam logic [2:0] REG_MOVE_ENTER   = 3'd3;
  localparam logic [2:0] REG_STILL_ENTER  = 3'd4;
  localparam logic [2:0] REG_SETTLE       = 3'd5;
  localparam logic [2:0] REG_STILL_ALERT  = 3'd6;
  localparam logic [2:0] REG_REST_ALERT   = 3'd7;

  // Register reset values.
  localparam logic [17:0] RST_MOVE_ACCEL   = 18'd45;
  localparam logic [16:0] RST_MOVE_GYRO    = 17'd5000;
  localparam logic [17:0] RST_IMPACT_ACCEL = 18'd650;
  localparam logic [3:0]  RST_MOVE_ENTER   = 4'd2;
  localparam logic [3:0]  RST_STILL_ENTER  = 4'd4;
  localparam logic [7:0]  RST_SETTLE       = 8'd3;
  localparam logic [31:0] RST_STILL_ALERT  = 32'd15;
  localparam logic [31:0] RST_REST_ALERT   = 32'd2700;

  localparam logic [7:0] SETTLE_MAX = 8'd255;

endpackage

// ===== hw/rtl/ride_motion_impact_classifier.sv =====
// ----------------------------------------------------------------------------
// ride_motion_impact_classifier
// Ride tracker that classifies IMU samples as still or moving and raises
// impact, still and rest alerts on second ticks.
// ----------------------------------------------------------------------------
// The block takes one command item per clock cycle and returns one result
// item for each, in the cycle after the command is accepted. All work for a
// command (axis differences, absolute sums, threshold compares, score and
// counter updates) is combinational and lands directly in the ride
// state registers, which also drive the result ports. A new command is taken
// whenever no result is waiting or the waiting result is taken in the same
// cycle, so the sustained rate is one item per cycle as long as the result
// side does not stall. Configuration registers sit on a 32-bit APB-style port
// at byte addresses 4*i and should be written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ride_motion_impact_classifier #(
  parameter int WARMUP_LEN = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // Command channel
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic [2:0]                opcode,
  input  logic signed [15:0]        accel_x,
  input  logic signed [15:0]        accel_y,
  input  logic signed [15:0]        accel_z,
  input  logic signed [15:0]        gyro_x,
  input  logic signed [15:0]        gyro_y,
  input  logic signed [15:0]        gyro_z,
  // Result channel
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [1:0]                motion_state,
  output logic [1:0]                alert_code,
  output logic                      ride_active,
  output logic                      ride_paused,
  output logic [31:0]               elapsed_seconds,
  output logic [31:0]               moving_seconds,
  output logic [31:0]               still_seconds,
  output logic [15:0]               impact_total,
  output logic [15:0]               pause_total,
  output logic [15:0]               rest_total,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rmic_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import rmic_pkg::*;

`include "ride_motion_impact_classifier_assert.svh"

  localparam int WarmW = $clog2(WARMUP_LEN + 1);
  localparam logic [WarmW-1:0] WarmDone = WarmW'(WARMUP_LEN);

  // Configuration registers
  logic [17:0] move_accel_delta;
  logic [16:0] move_gyro_sum;
  logic [17:0] impact_accel_delta;
  logic [3:0]  moving_enter_count;
  logic [3:0]  still_enter_count;
  logic [7:0]  impact_settle_seconds;
  logic [31:0] still_alert_limit;
  logic [31:0] rest_alert_limit;

  // Ride state
  logic signed [15:0] prev_accel_x, prev_accel_y, prev_accel_z;
  logic [WarmW-1:0]   warmup_count;
  logic [3:0]         move_run, calm_run;
  logic [7:0]         settle_seconds;
  logic               impact_armed, rest_done, still_done;
  logic               active_flag, paused_flag;
  logic [1:0]         motion_reg, alert_reg;
  logic [31:0]        elapsed_count, moving_count, still_count;
  logic [15:0]        impact_count_reg, pause_count_reg, rest_count_reg;

  logic signed [15:0] prev_accel_x_next, prev_accel_y_next, prev_accel_z_next;
  logic [WarmW-1:0]   warmup_count_next;
  logic [3:0]         move_run_next, calm_run_next;
  logic [7:0]         settle_seconds_next;
  logic               impact_armed_next, rest_done_next, still_done_next;
  logic               active_flag_next, paused_flag_next;
  logic [1:0]         motion_reg_next, alert_reg_next;
  logic [31:0]        elapsed_count_next, moving_count_next, still_count_next;
  logic [15:0]        impact_count_reg_next, pause_count_reg_next, rest_count_reg_next;

  logic cmd_accept;
  logic cfg_write;

  // Sample arithmetic
  logic signed [16:0] dx, dy, dz;
  logic [16:0]        adx, ady, adz;
  logic [15:0]        agx, agy, agz;
  logic [17:0]        dacc;
  logic [16:0]        gsum;
  logic               is_impact, is_moving;

  assign cmd_stall  = res_valid & res_stall;
  assign cmd_accept = cmd_valid & ~cmd_stall;

  assign dx = 17'(accel_x) - 17'(prev_accel_x);
  assign dy = 17'(accel_y) - 17'(prev_accel_y);
  assign dz = 17'(accel_z) - 17'(prev_accel_z);
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign adz = dz[16] ? 17'(-dz) : 17'(dz);
  // The most negative rate maps to 0x8000, read here as unsigned 32768.
  assign agx = gyro_x[15] ? 16'(~gyro_x + 16'sd1) : 16'(gyro_x);
  assign agy = gyro_y[15] ? 16'(~gyro_y + 16'sd1) : 16'(gyro_y);
  assign agz = gyro_z[15] ? 16'(~gyro_z + 16'sd1) : 16'(gyro_z);
  assign dacc = 18'(adx) + 18'(ady) + 18'(adz);
  assign gsum = 17'(agx) + 17'(agy) + 17'(agz);
  assign is_impact = dacc >= impact_accel_delta;
  assign is_moving = (dacc >= move_accel_delta) || (gsum >= move_gyro_sum);

  always_comb begin
    prev_accel_x_next     = prev_accel_x;
    prev_accel_y_next     = prev_accel_y;
    prev_accel_z_next     = prev_accel_z;
    warmup_count_next     = warmup_count;
    move_run_next         = move_run;
    calm_run_next         = calm_run;
    settle_seconds_next   = settle_seconds;
    impact_armed_next     = impact_armed;
    rest_done_next        = rest_done;
    still_done_next       = still_done;
    active_flag_next      = active_flag;
    paused_flag_next      = paused_flag;
    motion_reg_next       = motion_reg;
    alert_reg_next        = alert_reg;
    elapsed_count_next    = elapsed_count;
    moving_count_next     = moving_count;
    still_count_next      = still_count;
    impact_count_reg_next = impact_count_reg;
    pause_count_reg_next  = pause_count_reg;
    rest_count_reg_next   = rest_count_reg;

    unique case (opcode)
      OP_SAMPLE: begin
        if (active_flag && !paused_flag) begin
          prev_accel_x_next = accel_x;
          prev_accel_y_next = accel_y;
          prev_accel_z_next = accel_z;
          if (warmup_count < WarmDone) begin
            warmup_count_next = warmup_count + 1'b1;
            if (warmup_count_next == WarmDone) begin
              motion_reg_next = MOTION_STILL;
            end
          end else begin
            if (is_impact && !impact_armed) begin
              impact_armed_next     = 1'b1;
              settle_seconds_next   = '0;
              impact_count_reg_next = impact_count_reg + 16'd1;
            end
            if (is_moving) begin
              if (move_run < moving_enter_count) begin
                move_run_next = move_run + 4'd1;
              end
              calm_run_next = '0;
              if (move_run_next >= moving_enter_count) begin
                motion_reg_next = MOTION_MOVING;
                still_done_next = 1'b0;
              end
            end else begin
              if (calm_run < still_enter_count) begin
                calm_run_next = calm_run + 4'd1;
              end
              move_run_next = '0;
              if (calm_run_next >= still_enter_count) begin
                motion_reg_next = MOTION_STILL;
              end
            end
          end
        end
      end
      OP_SECOND: begin
        if (active_flag && !paused_flag) begin
          elapsed_count_next = elapsed_count + 32'd1;
          if (motion_reg == MOTION_MOVING) begin
            moving_count_next   = moving_count + 32'd1;
            settle_seconds_next = '0;
          end else if (motion_reg == MOTION_STILL) begin
            still_count_next = still_count + 32'd1;
            if (impact_armed && settle_seconds < SETTLE_MAX) begin
              settle_seconds_next = settle_seconds + 8'd1;
            end
          end
          // At most one alert per tick, impact first.
          priority if (impact_armed && settle_seconds_next >= impact_settle_seconds) begin
            alert_reg_next    = ALERT_IMPACT;
            impact_armed_next = 1'b0;
          end else if (!still_done && motion_reg == MOTION_STILL &&
                       still_count_next >= still_alert_limit) begin
            alert_reg_next  = ALERT_STILL;
            still_done_next = 1'b1;
          end else if (!rest_done && moving_count_next >= rest_alert_limit) begin
            alert_reg_next      = ALERT_REST;
            rest_done_next      = 1'b1;
            rest_count_reg_next = rest_count_reg + 16'd1;
          end else begin
            alert_reg_next = alert_reg;
          end
        end
      end
      OP_START: begin
        prev_accel_x_next     = '0;
        prev_accel_y_next     = '0;
        prev_accel_z_next     = '0;
        warmup_count_next     = '0;
        move_run_next         = '0;
        calm_run_next         = '0;
        settle_seconds_next   = '0;
        impact_armed_next     = 1'b0;
        rest_done_next        = 1'b0;
        still_done_next       = 1'b0;
        paused_flag_next      = 1'b0;
        motion_reg_next       = MOTION_UNKNOWN;
        alert_reg_next        = ALERT_NONE;
        elapsed_count_next    = '0;
        moving_count_next     = '0;
        still_count_next      = '0;
        impact_count_reg_next = '0;
        pause_count_reg_next  = '0;
        rest_count_reg_next   = '0;
        active_flag_next      = 1'b1;
      end
      OP_PAUSE: begin
        if (active_flag && !paused_flag) begin
          paused_flag_next     = 1'b1;
          pause_count_reg_next = pause_count_reg + 16'd1;
        end
      end
      OP_RESUME: begin
        if (active_flag && paused_flag) begin
          paused_flag_next = 1'b0;
        end
      end
      OP_ACK: begin
        alert_reg_next = ALERT_NONE;
      end
      OP_FINISH: begin
        active_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_accel_x     <= '0;
      prev_accel_y     <= '0;
      prev_accel_z     <= '0;
      warmup_count     <= '0;
      move_run         <= '0;
      calm_run         <= '0;
      settle_seconds   <= '0;
      impact_armed     <= 1'b0;
      rest_done        <= 1'b0;
      still_done       <= 1'b0;
      active_flag      <= 1'b0;
      paused_flag      <= 1'b0;
      motion_reg       <= MOTION_UNKNOWN;
      alert_reg        <= ALERT_NONE;
      elapsed_count    <= '0;
      moving_count     <= '0;
      still_count      <= '0;
      impact_count_reg <= '0;
      pause_count_reg  <= '0;
      rest_count_reg   <= '0;
    end else if (cmd_accept) begin
      prev_accel_x     <= prev_accel_x_next;
      prev_accel_y     <= prev_accel_y_next;
      prev_accel_z     <= prev_accel_z_next;
      warmup_count     <= warmup_count_next;
      move_run         <= move_run_next;
      calm_run         <= calm_run_next;
      settle_seconds   <= settle_seconds_next;
      impact_armed     <= impact_armed_next;
      rest_done        <= rest_done_next;
      still_done       <= still_done_next;
      active_flag      <= active_flag_next;
      paused_flag      <= paused_flag_next;
      motion_reg       <= motion_reg_next;
      alert_reg        <= alert_reg_next;
      elapsed_count    <= elapsed_count_next;
      moving_count     <= moving_count_next;
      still_count      <= still_count_next;
      impact_count_reg <= impact_count_reg_next;
      pause_count_reg  <= pause_count_reg_next;
      rest_count_reg   <= rest_count_reg_next;
    end
  end

  // The state registers hold the result of the last item; they only change
  // when a new item is accepted, which needs the waiting result to be gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  assign motion_state    = motion_reg;
  assign alert_code      = alert_reg;
  assign ride_active     = active_flag;
  assign ride_paused     = paused_flag;
  assign elapsed_seconds = elapsed_count;
  assign moving_seconds  = moving_count;
  assign still_seconds   = still_count;
  assign impact_total    = impact_count_reg;
  assign pause_total     = pause_count_reg;
  assign rest_total      = rest_count_reg;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_accel_delta      <= RST_MOVE_ACCEL;
      move_gyro_sum         <= RST_MOVE_GYRO;
      impact_accel_delta    <= RST_IMPACT_ACCEL;
      moving_enter_count    <= RST_MOVE_ENTER;
      still_enter_count     <= RST_STILL_ENTER;
      impact_settle_seconds <= RST_SETTLE;
      still_alert_limit     <= RST_STILL_ALERT;
      rest_alert_limit      <= RST_REST_ALERT;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_MOVE_ACCEL:   move_accel_delta      <= pwdata[17:0];
        REG_MOVE_GYRO:    move_gyro_sum         <= pwdata[16:0];
        REG_IMPACT_ACCEL: impact_accel_delta    <= pwdata[17:0];
        REG_MOVE_ENTER:   moving_enter_count    <= pwdata[3:0];
        REG_STILL_ENTER:  still_enter_count     <= pwdata[3:0];
        REG_SETTLE:       impact_settle_seconds <= pwdata[7:0];
        REG_STILL_ALERT:  still_alert_limit     <= pwdata;
        REG_REST_ALERT:   rest_alert_limit      <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MOVE_ACCEL:   prdata = 32'(move_accel_delta);
      REG_MOVE_GYRO:    prdata = 32'(move_gyro_sum);
      REG_IMPACT_ACCEL: prdata = 32'(impact_accel_delta);
      REG_MOVE_ENTER:   prdata = 32'(moving_enter_count);
      REG_STILL_ENTER:  prdata = 32'(still_enter_count);
      REG_SETTLE:       prdata = 32'(impact_settle_seconds);
      REG_STILL_ALERT:  prdata = still_alert_limit;
      REG_REST_ALERT:   prdata = rest_alert_limit;
      default:          prdata = '0;
    endcase
  end

  // Assertions
  `RMIC_ASSERT_NXT(a_start_clears, clk, rst, cmd_accept && opcode == OP_START,
    res_valid && active_flag && elapsed_count == 32'd0 && alert_reg == ALERT_NONE,
    "start item did not open a clean ride")
  `RMIC_ASSERT_IMP(a_warmup_bound, clk, rst, 1'b1, warmup_count <= WarmDone,
    "warm-up count ran past its limit")
  `RMIC_ASSERT_IMP(a_warmup_unknown, clk, rst, warmup_count < WarmDone,
    motion_reg == MOTION_UNKNOWN, "motion classified before warm-up finished")
  `RMIC_ASSERT_IMP(a_rest_flag, clk, rst, alert_reg == ALERT_REST, rest_done,
    "rest alert shown without its done flag")

endmodule

// ===== tb/ride_motion_impact_classifier_test.sv =====
// ----------------------------------------------------------------------------
// ride_motion_impact_classifier_test
// Self-checking bench for the ride classifier. Every command item drives a
// cycle-free copy of the ride tracker, and each result item from the block is
// compared field by field against the oldest prediction. Directed items cover
// the commands and threshold corners, then random rides run under several
// threshold settings with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ride_motion_impact_classifier_test;
  import rmic_pkg::*;

  localparam int WARMUP = 8;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [15:0] AXIS_MAX = 16'h7FFF;
  localparam logic [15:0] AXIS_MIN = 16'h8000;
  localparam logic [31:0] ACCEL_TOP = 32'h3FFFF;
  localparam logic [31:0] GYRO_TOP = 32'h1FFFF;
  localparam logic [31:0] COUNT_TOP = 32'hF;
  localparam logic [31:0] SECONDS_TOP = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] ax, ay, az, gx, gy, gz;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  motion;
    logic [1:0]  alert;
    logic        active;
    logic        paused;
    logic [31:0] elapsed, moving, still;
    logic [15:0] impacts, pauses, rests;
  } status_t;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  wire cmd_stall;
  logic [2:0] opcode = OP_SAMPLE;
  logic [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  wire res_valid;
  logic res_stall = 1'b0;
  wire [1:0] motion_state, alert_code;
  wire ride_active, ride_paused;
  wire [31:0] elapsed_seconds, moving_seconds, still_seconds;
  wire [15:0] impact_total, pause_total, rest_total;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0] prdata;
  wire pready;

  ride_motion_impact_classifier #(.WARMUP_LEN(WARMUP)) DUT (.*);

  // Threshold registers as the block should hold them.
  logic [17:0] thr_move_accel = RST_MOVE_ACCEL;
  logic [16:0] thr_move_gyro = RST_MOVE_GYRO;
  logic [17:0] thr_impact_accel = RST_IMPACT_ACCEL;
  logic [3:0]  thr_move_enter = RST_MOVE_ENTER;
  logic [3:0]  thr_still_enter = RST_STILL_ENTER;
  logic [7:0]  thr_settle = RST_SETTLE;
  logic [31:0] thr_still_alert = RST_STILL_ALERT;
  logic [31:0] thr_rest_alert = RST_REST_ALERT;

  // Ride state of the predictor.
  logic [15:0] last_ax, last_ay, last_az;
  logic [3:0]  warm_cnt, move_score, calm_score;
  logic [7:0]  settle_cnt;
  logic        impact_armed, rest_done, still_done, ride_held;
  logic        ride_on = 1'b0;
  logic [1:0]  motion, alert;
  logic [31:0] elapsed_secs, moving_secs, still_secs;
  logic [15:0] impacts, pauses, rests;

  status_t pending_status[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [15:0] jitter(int m);
    return 16'(int'($urandom_range(2 * m)) - m);
  endfunction

  function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi,
                                             logic [31:0] top);
    case ($urandom_range(9))
      0: return '0;
      1: return top;
      2: return $urandom & top;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic void clear_ride();
    last_ax = '0;
    last_ay = '0;
    last_az = '0;
    warm_cnt = '0;
    move_score = '0;
    calm_score = '0;
    settle_cnt = '0;
    impact_armed = 1'b0;
    rest_done = 1'b0;
    still_done = 1'b0;
    ride_held = 1'b0;
    motion = MOTION_UNKNOWN;
    alert = ALERT_NONE;
    elapsed_secs = '0;
    moving_secs = '0;
    still_secs = '0;
    impacts = '0;
    pauses = '0;
    rests = '0;
  endfunction

  function automatic status_t advance_ride(cmd_t c);
    int dacc, gsum;
    logic hit_move, hit_impact;
    status_t s;
    case (c.op)
      OP_SAMPLE: if (ride_on && !ride_held) begin
        if (warm_cnt < WARMUP) begin
          last_ax = c.ax;
          last_ay = c.ay;
          last_az = c.az;
          warm_cnt++;
          if (warm_cnt == WARMUP) motion = MOTION_STILL;
        end else begin
          dacc = iabs(int'($signed(c.ax)) - int'($signed(last_ax))) +
                 iabs(int'($signed(c.ay)) - int'($signed(last_ay))) +
                 iabs(int'($signed(c.az)) - int'($signed(last_az)));
          gsum = iabs(int'($signed(c.gx))) + iabs(int'($signed(c.gy))) +
                 iabs(int'($signed(c.gz)));
          hit_impact = dacc >= int'(thr_impact_accel);
          hit_move = dacc >= int'(thr_move_accel) || gsum >= int'(thr_move_gyro);
          last_ax = c.ax;
          last_ay = c.ay;
          last_az = c.az;
          if (hit_impact && !impact_armed) begin
            impact_armed = 1'b1;
            settle_cnt = '0;
            impacts++;
          end
          if (hit_move) begin
            if (move_score < thr_move_enter) move_score++;
            calm_score = '0;
            if (move_score >= thr_move_enter) begin
              motion = MOTION_MOVING;
              still_done = 1'b0;
            end
          end else begin
            if (calm_score < thr_still_enter) calm_score++;
            move_score = '0;
            if (calm_score >= thr_still_enter) motion = MOTION_STILL;
          end
        end
      end
      OP_SECOND: if (ride_on && !ride_held) begin
        elapsed_secs++;
        if (motion == MOTION_MOVING) begin
          moving_secs++;
          settle_cnt = '0;
        end else if (motion == MOTION_STILL) begin
          still_secs++;
          if (impact_armed && settle_cnt < SETTLE_MAX) settle_cnt++;
        end
        // At most one alert per tick, impact first.
        if (impact_armed && settle_cnt >= thr_settle) begin
          alert = ALERT_IMPACT;
          impact_armed = 1'b0;
        end else if (!still_done && motion == MOTION_STILL &&
                     still_secs >= thr_still_alert) begin
          alert = ALERT_STILL;
          still_done = 1'b1;
        end else if (!rest_done && moving_secs >= thr_rest_alert) begin
          alert = ALERT_REST;
          rest_done = 1'b1;
          rests++;
        end
      end
      OP_START: begin
        clear_ride();
        ride_on = 1'b1;
      end
      OP_PAUSE: if (ride_on && !ride_held) begin
        ride_held = 1'b1;
        pauses++;
      end
      OP_RESUME: if (ride_on && ride_held) ride_held = 1'b0;
      OP_ACK: alert = ALERT_NONE;
      OP_FINISH: ride_on = 1'b0;
      default: ;
    endcase
    s.motion = motion;
    s.alert = alert;
    s.active = ride_on;
    s.paused = ride_held;
    s.elapsed = elapsed_secs;
    s.moving = moving_secs;
    s.still = still_secs;
    s.impacts = impacts;
    s.pauses = pauses;
    s.rests = rests;
    return s;
  endfunction

  function automatic cmd_t random_cmd(logic [2:0] op);
    cmd_t c;
    c.op = op;
    c.ax = 16'($urandom);
    c.ay = 16'($urandom);
    c.az = 16'($urandom);
    c.gx = 16'($urandom);
    c.gy = 16'($urandom);
    c.gz = 16'($urandom);
    return c;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    status_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result item with no prediction waiting");
      end else begin
        want = pending_status.pop_front();
        check_field("motion_state", 32'(want.motion), 32'(motion_state));
        check_field("alert_code", 32'(want.alert), 32'(alert_code));
        check_field("ride_active", 32'(want.active), 32'(ride_active));
        check_field("ride_paused", 32'(want.paused), 32'(ride_paused));
        check_field("elapsed_seconds", want.elapsed, elapsed_seconds);
        check_field("moving_seconds", want.moving, moving_seconds);
        check_field("still_seconds", want.still, still_seconds);
        check_field("impact_total", 32'(want.impacts), 32'(impact_total));
        check_field("pause_total", 32'(want.pauses), 32'(pause_total));
        check_field("rest_total", 32'(want.rests), 32'(rest_total));
      end
    end
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_cmd(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    opcode <= c.op;
    accel_x <= c.ax;
    accel_y <= c.ay;
    accel_z <= c.az;
    gyro_x <= c.gx;
    gyro_y <= c.gy;
    gyro_z <= c.gz;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_status.push_back(advance_ride(c));
  endtask

  task automatic send_op(logic [2:0] op);
    send_cmd(random_cmd(op));
  endtask

  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    cmd_t c;
    c = '{op: OP_SAMPLE, ax: ax, ay: ay, az: az, gx: gx, gy: gy, gz: gz};
    send_cmd(c);
  endtask

  task automatic wait_quiet();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MOVE_ACCEL:   thr_move_accel = val[17:0];
      REG_MOVE_GYRO:    thr_move_gyro = val[16:0];
      REG_IMPACT_ACCEL: thr_impact_accel = val[17:0];
      REG_MOVE_ENTER:   thr_move_enter = val[3:0];
      REG_STILL_ENTER:  thr_still_enter = val[3:0];
      REG_SETTLE:       thr_settle = val[7:0];
      REG_STILL_ALERT:  thr_still_alert = val;
      REG_REST_ALERT:   thr_rest_alert = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_thresholds(logic [31:0] move_accel, logic [31:0] move_gyro,
                                 logic [31:0] impact_accel, logic [31:0] move_enter,
                                 logic [31:0] still_enter, logic [31:0] settle,
                                 logic [31:0] still_alert, logic [31:0] rest_alert);
    wait_quiet();
    write_reg(REG_MOVE_ACCEL, move_accel);
    write_reg(REG_MOVE_GYRO, move_gyro);
    write_reg(REG_IMPACT_ACCEL, impact_accel);
    write_reg(REG_MOVE_ENTER, move_enter);
    write_reg(REG_STILL_ENTER, still_enter);
    write_reg(REG_SETTLE, settle);
    write_reg(REG_STILL_ALERT, still_alert);
    write_reg(REG_REST_ALERT, rest_alert);
  endtask

  // Every command with the reset thresholds, including the ones that must be
  // ignored while no ride runs or while it is paused.
  task automatic test_command_set();
    send_sample(AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN);
    send_op(OP_SECOND);
    send_op(OP_PAUSE);
    send_op(OP_RESUME);
    send_op(OP_UNUSED);
    send_op(OP_ACK);
    send_op(OP_START);
    send_op(OP_RESUME);
    for (int i = 0; i < WARMUP; i++) begin
      send_sample(i[0] ? AXIS_MIN : AXIS_MAX, i[0] ? AXIS_MIN : AXIS_MAX,
                  i[0] ? AXIS_MIN : AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MAX);
    end
    // Full-scale swing on all axes with the gyro pinned at its negative limit.
    send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MIN, AXIS_MIN);
    send_op(OP_SECOND);
    send_op(OP_PAUSE);
    send_op(OP_PAUSE);
    send_op(OP_SECOND);
    send_sample('0, '0, '0, '0, '0, '0);
    send_op(OP_RESUME);
    send_op(OP_ACK);
    send_op(OP_FINISH);
    send_op(OP_SECOND);
  endtask

  task automatic test_threshold_corners();
    // All zero: every sample moves at once, and the alerts fire immediately.
    load_thresholds('0, '0, '0, '0, '0, '0, '0, '0);
    send_op(OP_START);
    repeat (WARMUP + 1) send_op(OP_SAMPLE);
    send_op(OP_SECOND);
    send_op(OP_SECOND);
    send_op(OP_ACK);
    send_op(OP_SECOND);
    send_op(OP_PAUSE);
    send_op(OP_SECOND);
    send_op(OP_RESUME);
    send_op(OP_FINISH);
    // All at the top: even a full-scale swing stays below the thresholds.
    load_thresholds(ACCEL_TOP, GYRO_TOP, ACCEL_TOP, COUNT_TOP, COUNT_TOP,
                    32'(SETTLE_MAX), SECONDS_TOP, SECONDS_TOP);
    send_op(OP_START);
    repeat (WARMUP - 1) send_op(OP_SAMPLE);
    send_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN, '0, '0, '0);
    send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MIN, AXIS_MIN);
    send_op(OP_SECOND);
    send_op(OP_SECOND);
    send_op(OP_FINISH);
  endtask

  // An impact followed by a long still stretch runs the settle counter to
  // its ceiling before the impact alert is raised.
  task automatic test_settle_limit();
    idle_pct = 13;
    stall_pct = 13;
    load_thresholds(32'(RST_MOVE_ACCEL), 32'(RST_MOVE_GYRO), 32'(RST_IMPACT_ACCEL),
                    32'(RST_MOVE_ENTER), 32'(RST_STILL_ENTER), 32'(SETTLE_MAX),
                    SECONDS_TOP, SECONDS_TOP);
    send_op(OP_START);
    repeat (WARMUP) send_sample('0, '0, '0, '0, '0, '0);
    send_sample(16'd1000, '0, '0, '0, '0, '0);
    repeat (6) send_sample('0, '0, '0, '0, '0, '0);
    repeat (int'(SETTLE_MAX) + 1) send_op(OP_SECOND);
  endtask

  task automatic run_random_rides(int n);
    int count, r, m, da, dg;
    logic [15:0] cur_ax, cur_ay, cur_az;
    cmd_t c;
    count = 0;
    cur_ax = '0;
    cur_ay = '0;
    cur_az = '0;
    while (count < n) begin
      r = $urandom_range(99);
      c = random_cmd(OP_SAMPLE);
      if (!ride_on && r < 70) c.op = OP_START;
      else if (r < 1) c.op = OP_START;
      else if (r < 2) c.op = OP_FINISH;
      else if (r < 4) c.op = OP_PAUSE;
      else if (r < 12) c.op = OP_RESUME;
      else if (r < 16) c.op = OP_ACK;
      else if (r < 18) c.op = ($urandom_range(3) == 0) ? OP_UNUSED : 3'($urandom_range(7));
      else if (r < 50) c.op = OP_SECOND;
      else begin
        // Mostly small, moderate or violent motion around the last reading;
        // the rest keep fully random fields.
        m = $urandom_range(9);
        if (m < 8) begin
          da = (m < 4) ? 12 : (m < 7) ? 150 : 2500;
          dg = (m < 4) ? 1500 : (m < 7) ? 9000 : 32767;
          c.ax = cur_ax + jitter(da);
          c.ay = cur_ay + jitter(da);
          c.az = cur_az + jitter(da);
          c.gx = jitter(dg);
          c.gy = jitter(dg);
          c.gz = jitter(dg);
        end
      end
      if (c.op == OP_SAMPLE) begin
        cur_ax = c.ax;
        cur_ay = c.ay;
        cur_az = c.az;
      end
      if (ride_on || c.op == OP_START) count++;
      send_cmd(c);
      if ($urandom_range(149) == 0) wait_quiet();
    end
  endtask

  task automatic test_random_rides();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) begin
        load_thresholds(32'(RST_MOVE_ACCEL), 32'(RST_MOVE_GYRO), 32'(RST_IMPACT_ACCEL),
                        32'(RST_MOVE_ENTER), 32'(RST_STILL_ENTER), 32'(RST_SETTLE),
                        RST_STILL_ALERT, RST_REST_ALERT);
      end else begin
        load_thresholds(pick_value(20, 300, ACCEL_TOP), pick_value(1000, 20000, GYRO_TOP),
                        pick_value(300, 5000, ACCEL_TOP), pick_value(1, 4, COUNT_TOP),
                        pick_value(1, 6, COUNT_TOP), pick_value(0, 6, 32'(SETTLE_MAX)),
                        pick_value(0, 20, SECONDS_TOP), pick_value(0, 20, SECONDS_TOP));
      end
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 63;
        end
        3: begin
          idle_pct = 13;
          stall_pct = 13;
        end
        default: begin
          idle_pct = ($urandom_range(1) == 0) ? 0 : 63;
          stall_pct = ($urandom_range(1) == 0) ? 13 : 63;
        end
      endcase
      run_random_rides(140);
    end
  endtask

  initial begin
    clear_ride();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_command_set();
    test_threshold_corners();
    test_settle_limit();
    test_random_rides();
    wait_quiet();
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
